/* design/vsfg_pkg.sv */
package vsfg_pkg;

  localparam int MaxSide = 64;
  localparam int SideW = $clog2(MaxSide + 1);
  localparam int IdxW = $clog2(MaxSide * MaxSide);
  localparam int CoordW = $clog2(MaxSide);
  localparam int CellsW = IdxW + 1;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_VOXEL  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_FREE    = 2'd1,
    CELL_OCC     = 2'd2,
    CELL_DRONE   = 2'd3
  } cell_t;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_HALF = 2'd1;
  localparam logic [1:0] REG_CELLS = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  typedef struct packed {
    logic [15:0] cell_scale;
    logic [15:0] slice_half_thickness;
    logic [6:0]  grid_cells;
    logic [12:0] starve_level;
  } cfg_t;

endpackage

/* design/voxel_slice_frontier_grid.sv */
// Altitude-slice occupancy grid. Commands enter on start while busy is low; finish
// and read commands give one result beat marked by done, which the receiver must take
// in that cycle. The grid is one 4096x2 synchronous RAM with a single port pair, so
// each command walks its steps through the one port: begin clears every entry in a sweep;
// voxel steps through accept, bin multiply, address, read and write back (it ends
// after accept when outside the slice, after the multiply when outside the grid); read
// steps through accept, read and result (result at once when the index is outside the
// grid); finish walks every interior cell with one address step and five reads each.
// After reset the block runs one clearing pass over every entry with busy high.
module voxel_slice_frontier_grid
  import vsfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [15:0]        occupancy,
  input  logic [11:0]        cell_index,
  output logic               done,
  output logic [1:0]         cell_value,
  output logic [12:0]        front_cells,
  output logic [15:0]        occ_total,
  output logic [15:0]        free_total,
  output logic               starved,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VMUL, S_VADDR, S_VRD, S_VWR, S_RRD, S_RWAIT,
    S_FMARK, S_FCEN, S_FNB, S_FDONE
  } state_t;

  cfg_t cfg;
  state_t state;

  vsfg_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );
  assign pready = 1'b1;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [1:0]      wdata, rdata;

  vsfg_ram #(.Depth(MaxSide * MaxSide), .Width(2)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic signed [23:0] drone_x, drone_y, drone_alt;
  logic [15:0]        occ_tally, free_tally;
  logic [IdxW:0]      clr;
  logic [SideW-1:0]   n;
  logic               v_occ;
  logic signed [41:0] tx, ty;
  logic [IdxW-1:0]    vaddr;
  logic [CoordW-1:0]  fx, fy;
  logic [2:0]         nb;
  logic               is_free, has_unk;
  logic [12:0]        fc;

  always_comb begin
    n = cfg.grid_cells;
    if (cfg.grid_cells < 7'd3) n = SideW'(3);
    if (cfg.grid_cells > 7'(MaxSide)) n = SideW'(MaxSide);
  end

  // truncate toward zero of (d*scale + n*32768) >> 16
  function automatic logic signed [42:0] trunc16(input logic signed [41:0] t);
    logic [41:0] m;
    m = t[41] ? 42'(-t) : t;
    m = m >> 16;
    return t[41] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic signed [42:0] cx, cy;
  logic signed [25:0] zlo, zhi;
  logic signed [24:0] dx, dy;
  assign cx = trunc16(tx + 42'(n) * 42'sd32768);
  assign cy = trunc16(ty + 42'(n) * 42'sd32768);
  assign dx = 25'(pos_x) - 25'(drone_x);
  assign dy = 25'(pos_y) - 25'(drone_y);
  assign zlo = 26'(drone_alt) - 26'($signed({1'b0, cfg.slice_half_thickness}));
  assign zhi = 26'(drone_alt) + 26'($signed({1'b0, cfg.slice_half_thickness}));

  logic [IdxW-1:0] cen, base, cen_i;
  logic [CoordW-1:0] half;
  assign half = CoordW'(n >> 1);
  assign base = IdxW'(fy) * IdxW'(n) + IdxW'(fx);
  assign cen = IdxW'(half) * IdxW'(n) + IdxW'(half);
  assign busy = (state != S_IDLE);
  assign we = (state == S_CLEAR) ||
              (state == S_VWR && (v_occ || rdata != CELL_OCC)) ||
              (state == S_FMARK);
  assign waddr = (state == S_CLEAR) ? clr[IdxW-1:0] :
                 (state == S_FMARK) ? cen : vaddr;
  assign wdata = (state == S_CLEAR) ? CELL_UNKNOWN :
                 (state == S_FMARK) ? CELL_DRONE : (v_occ ? CELL_OCC : CELL_FREE);
  assign cen_i = base;

  always_comb begin
    raddr = vaddr;
    if (state == S_FCEN || state == S_FNB) begin
      case (nb)
        3'd0: raddr = cen_i;
        3'd1: raddr = cen_i + IdxW'(n);
        3'd2: raddr = cen_i - IdxW'(n);
        3'd3: raddr = cen_i + IdxW'(1);
        default: raddr = cen_i - IdxW'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
      drone_x <= '0;
      drone_y <= '0;
      drone_alt <= 24'sd384;
      occ_tally <= '0;
      free_tally <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr[IdxW-1:0] == IdxW'(MaxSide * MaxSide - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          v_occ <= occupancy > 16'd32768;
          case (mode_t'(mode))
            MODE_BEGIN: begin
              drone_x <= pos_x;
              drone_y <= pos_y;
              drone_alt <= pos_z;
              occ_tally <= '0;
              free_tally <= '0;
              clr <= '0;
              state <= S_CLEAR;
            end
            MODE_VOXEL: begin
              if (26'(pos_z) >= zlo && 26'(pos_z) <= zhi) begin
                tx <= 42'(dx) * $signed({1'b0, cfg.cell_scale});
                ty <= 42'(dy) * $signed({1'b0, cfg.cell_scale});
                state <= S_VMUL;
              end
            end
            MODE_FINISH: state <= S_FMARK;
            default: begin
              vaddr <= cell_index;
              if ({1'b0, cell_index} < CellsW'(n) * CellsW'(n)) state <= S_RRD;
              else begin
                done <= 1'b1;
                cell_value <= CELL_UNKNOWN;
                front_cells <= '0;
                occ_total <= '0;
                free_total <= '0;
                starved <= 1'b0;
              end
            end
          endcase
        end
        S_VMUL: begin
          if (cx >= 0 && cx < 43'(n) && cy >= 0 && cy < 43'(n)) begin
            vaddr <= IdxW'(cy[CoordW-1:0]) * IdxW'(n) + IdxW'(cx[CoordW-1:0]);
            state <= S_VADDR;
          end else state <= S_IDLE;
        end
        S_VADDR: state <= S_VRD;
        S_VRD: state <= S_VWR;
        S_VWR: begin
          if (v_occ) begin
            if (occ_tally != 16'hFFFF) occ_tally <= occ_tally + 1'b1;
          end else if (rdata != CELL_OCC) begin
            if (free_tally != 16'hFFFF) free_tally <= free_tally + 1'b1;
          end
          state <= S_IDLE;
        end
        S_RRD: state <= S_RWAIT;
        S_RWAIT: begin
          done <= 1'b1;
          cell_value <= rdata;
          front_cells <= '0;
          occ_total <= '0;
          free_total <= '0;
          starved <= 1'b0;
          state <= S_IDLE;
        end
        S_FMARK: begin
          fx <= CoordW'(1);
          fy <= CoordW'(1);
          fc <= '0;
          nb <= '0;
          state <= (n > SideW'(2)) ? S_FCEN : S_FDONE;
        end
        S_FCEN: begin
          nb <= 3'd1;
          is_free <= 1'b0;
          has_unk <= 1'b0;
          state <= S_FNB;
        end
        S_FNB: begin
          // rdata holds the entry issued one step back
          if (nb == 3'd1) is_free <= (rdata == CELL_FREE);
          else if (rdata == CELL_UNKNOWN) has_unk <= 1'b1;
          if (nb == 3'd5) begin
            if (is_free && (has_unk || rdata == CELL_UNKNOWN) && fc != 13'd4096)
              fc <= fc + 1'b1;
            nb <= '0;
            if (SideW'(fx) == n - SideW'(2)) begin
              fx <= CoordW'(1);
              if (SideW'(fy) == n - SideW'(2)) state <= S_FDONE;
              else begin
                fy <= fy + 1'b1;
                state <= S_FCEN;
              end
            end else begin
              fx <= fx + 1'b1;
              state <= S_FCEN;
            end
          end else nb <= nb + 1'b1;
        end
        S_FDONE: begin
          done <= 1'b1;
          cell_value <= CELL_UNKNOWN;
          front_cells <= fc;
          occ_total <= occ_tally;
          free_total <= free_tally;
          starved <= fc < cfg.starve_level;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE || start)) else $error("result without command");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we) else $error("grid written while idle");
  a_occ_sat: assert property (@(posedge clk) disable iff (rst)
    $past(occ_tally) == 16'hFFFF && occ_tally != 16'd0 |-> occ_tally == 16'hFFFF)
    else $error("occupied tally wrapped");

endmodule

/* design/vsfg_ram.sv */
module vsfg_ram
  import vsfg_pkg::*;
#(
  parameter int Depth = 4096,
  parameter int Width = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/vsfg_cfg.sv */
module vsfg_cfg
  import vsfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic [1:0] sel;
  logic       hit;

  assign sel = paddr[3:2];
  assign hit = (paddr[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_scale <= 16'd1280;
      cfg.slice_half_thickness <= 16'd128;
      cfg.grid_cells <= 7'd50;
      cfg.starve_level <= 13'd5;
    end else if (psel && penable && pwrite && hit) begin
      case (sel)
        REG_SCALE:  cfg.cell_scale <= pwdata[15:0];
        REG_HALF:   cfg.slice_half_thickness <= pwdata[15:0];
        REG_CELLS:  cfg.grid_cells <= pwdata[6:0];
        REG_THRESH: cfg.starve_level <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (hit) begin
      case (sel)
        REG_SCALE:  prdata = {16'd0, cfg.cell_scale};
        REG_HALF:   prdata = {16'd0, cfg.slice_half_thickness};
        REG_CELLS:  prdata = {25'd0, cfg.grid_cells};
        REG_THRESH: prdata = {19'd0, cfg.starve_level};
        default:    prdata = 32'd0;
      endcase
    end
  end

endmodule
